// File: rtl/core/hds_pkg.sv
package hds_pkg;

    // Grid and sample geometry
    localparam int DATA_BITS   = 16;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int CFG_BITS    = 11;

    // Stencil sum: four times the centre plus four neighbours plus rounding
    localparam int SUM_BITS    = DATA_BITS + 3;

    // Output packing, padded up to whole bytes
    localparam int OUT_BITS    = DATA_BITS + ROW_BITS + COL_BITS;
    localparam int TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;
    localparam int PAD_BITS    = TDATA_BITS - OUT_BITS;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // Configuration register map (word index taken from paddr[2])
    localparam int  PADDR_BITS      = 3;
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // One window column: row r-2, row r-1 and row r at one column
    typedef struct packed {
        logic [DATA_BITS-1:0] top;
        logic [DATA_BITS-1:0] mid;
        logic [DATA_BITS-1:0] bot;
    } t_col;

    // One result transaction
    typedef struct packed {
        logic                 last;
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
        logic [DATA_BITS-1:0] temp;
    } t_result;

    // Clamp a dimension register to [3, maxv] and return the last index.
    function automatic logic [CFG_BITS-1:0] clamp_last(input logic [CFG_BITS-1:0] v,
                                                      input int unsigned maxv);
        logic [CFG_BITS-1:0] res;
        if (v < CFG_BITS'(3)) begin
            res = CFG_BITS'(2);
        end else if (v > CFG_BITS'(maxv)) begin
            res = CFG_BITS'(maxv - 1);
        end else begin
            res = v - CFG_BITS'(1);
        end
        return res;
    endfunction

endpackage

// File: rtl/core/hds_line_store.sv
// Line store holding the two previous rows side by side in one word:
// the upper half is row r-2, the lower half row r-1.
module hds_line_store (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [hds_pkg::COL_BITS-1:0]       i_wr_addr,
    input  logic [2*hds_pkg::DATA_BITS-1:0]    i_wr_data,
    input  logic                               i_rd_en,
    input  logic [hds_pkg::COL_BITS-1:0]       i_rd_addr,
    output logic [2*hds_pkg::DATA_BITS-1:0]    o_rd_data
);
    import hds_pkg::*;

    logic [2*DATA_BITS-1:0] r_mem [MAX_WIDTH];
    logic [2*DATA_BITS-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/hds_win_cell.sv
// One column cell of the stencil window. Cells are chained: each takes the
// column of its left neighbour whenever the window shifts.
module hds_win_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  hds_pkg::t_col i_col,
    output hds_pkg::t_col o_col
);
    import hds_pkg::*;

    t_col r_col;
    t_col n_col;

    // Take the neighbour's column on a shift, otherwise hold.
    always_comb begin
        n_col = r_col;
        if (i_shift) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

// File: rtl/core/hds_out_queue.sv
// Small result queue. Its full flag comes from a register, so the input
// side never waits on the downstream ready combinationally.
module hds_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  hds_pkg::t_result i_wr_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output hds_pkg::t_result o_rd_data
);
    import hds_pkg::*;

    t_result              r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] n_count;
    logic                 rd_en;

    assign o_valid   = (r_count != '0);
    assign o_full    = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign rd_en     = o_valid && i_ready;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = r_wr_ptr + QPTR_BITS'(1);
        end
        if (rd_en) begin
            n_rd_ptr = r_rd_ptr + QPTR_BITS'(1);
        end
        if (i_wr_en && !rd_en) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_wr_en && rd_en) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: rtl/core/heat_diffusion_stencil_step.sv
// One explicit heat-equation time step over a grid streamed in raster order,
// using a five-point stencil with gain 1/8: an interior cell becomes
// (4*centre + up + down + left + right + 4) >> 3, border cells are copied.
// Grid width and height are set over the register port (word 0 and word 1,
// clamped to 3..1024); any write restarts the frame at row 0, column 0.
// Results for row r-1 come out while row r streams in, so output lags the
// input by one row and one column; during the last row each input also
// releases its own border copy. The result queue takes at most one result
// per cycle, so an input cell holds the input side until its last result
// is queued. Cells in row zero, and first-column cells above the last row,
// release no result; other cells in rows one to H-2 release one, two at
// the right end; last-row cells release two, one at the first column and
// three at the right end. Each cell is registered in the working stage and
// its results pass through the result queue; a full queue stalls the input.
// No clearing pass follows reset.
module heat_diffusion_stencil_step (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input cells
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hds_pkg::DATA_BITS-1:0]     s_axis_tdata,  // [15:0] temperature
    // Updated cells
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] new_temperature, [25:16] out_row, [35:26] out_col, [39:36] zero
    output logic [hds_pkg::TDATA_BITS-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,  // frame_last
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hds_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import hds_pkg::*;

    // Configuration registers
    logic [CFG_BITS-1:0]  r_grid_width;
    logic [CFG_BITS-1:0]  r_grid_height;
    logic                 cfg_write;
    logic [CFG_BITS-1:0]  w_last_full;
    logic [CFG_BITS-1:0]  h_last_full;
    logic [COL_BITS-1:0]  w_last;
    logic [ROW_BITS-1:0]  h_last;

    // Input position counters
    logic [ROW_BITS-1:0]  r_row;
    logic [COL_BITS-1:0]  r_col;
    logic [ROW_BITS-1:0]  n_row;
    logic [COL_BITS-1:0]  n_col;
    logic                 in_acc;

    // Working stage
    logic                 r_b_valid;
    logic [2:0]           r_b_pend;
    logic [DATA_BITS-1:0] r_b_x;
    logic [ROW_BITS-1:0]  r_b_row;
    logic [COL_BITS-1:0]  r_b_col;
    logic                 n_b_valid;
    logic [2:0]           n_b_pend;
    logic [2:0]           new_pend;
    logic                 emit;
    logic                 retire;
    logic                 last_one;

    // Datapath
    logic [2*DATA_BITS-1:0] rd_data;
    logic [DATA_BITS-1:0]   top;
    logic [DATA_BITS-1:0]   mid;
    t_col                   col_in;
    t_col                   win0;
    t_col                   win1;
    logic [SUM_BITS-1:0]    sum;
    logic [DATA_BITS-1:0]   smooth;
    logic                   interior;
    t_result                res;
    logic                   q_full;
    t_result                q_out;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register writes; either one restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_BITS'(MAX_WIDTH);
            r_grid_height <= CFG_BITS'(MAX_HEIGHT);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_BITS-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_BITS-1:0];
                default:         r_grid_width  <= r_grid_width;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = 32'(r_grid_width);
            REG_GRID_HEIGHT: prdata = 32'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    assign w_last_full = clamp_last(r_grid_width, MAX_WIDTH);
    assign h_last_full = clamp_last(r_grid_height, MAX_HEIGHT);
    assign w_last      = w_last_full[COL_BITS-1:0];
    assign h_last      = h_last_full[ROW_BITS-1:0];

    // Raster position of the next input cell
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (cfg_write) begin
            n_row = '0;
            n_col = '0;
        end else if (in_acc) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Results an accepted cell releases: bit 0 the cell up and to the left,
    // bit 1 the right border copy of the row above, bit 2 the last-row copy.
    always_comb begin
        new_pend[0] = (r_row != '0) && (r_col != '0);
        new_pend[1] = (r_row != '0) && (r_col == w_last);
        new_pend[2] = (r_row != '0) && (r_row == h_last);
    end

    // Working stage hand-off: one pending result goes to the queue per cycle while the queue is not full.
    assign last_one      = ((r_b_pend & (r_b_pend - 3'd1)) == 3'd0);
    assign emit          = r_b_valid && (r_b_pend != 3'd0) && !q_full;
    assign retire        = r_b_valid && ((r_b_pend == 3'd0) || (emit && last_one));
    assign s_axis_tready = !r_b_valid || retire;

    always_comb begin
        n_b_valid = r_b_valid;
        n_b_pend  = r_b_pend;
        if (emit) begin
            n_b_pend = r_b_pend & (r_b_pend - 3'd1);
        end
        if (retire) begin
            n_b_valid = 1'b0;
        end
        if (in_acc) begin
            n_b_valid = 1'b1;
            n_b_pend  = new_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_pend  <= '0;
        end else begin
            r_b_valid <= n_b_valid;
            r_b_pend  <= n_b_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_x   <= s_axis_tdata;
            r_b_row <= r_row;
            r_b_col <= r_col;
        end
    end

    // Previous two rows, read as the cell is taken and updated as it retires
    hds_line_store u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (retire),
        .i_wr_addr (r_b_col),
        .i_wr_data ({mid, r_b_x}),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    assign top = rd_data[2*DATA_BITS-1:DATA_BITS];
    assign mid = rd_data[DATA_BITS-1:0];

    // Window: cell 0 holds column c-1, cell 1 column c-2
    assign col_in = '{top: top, mid: mid, bot: r_b_x};

    hds_win_cell u_cell0 (
        .i_clk   (i_clk),
        .i_shift (retire),
        .i_col   (col_in),
        .o_col   (win0)
    );

    hds_win_cell u_cell1 (
        .i_clk   (i_clk),
        .i_shift (retire),
        .i_col   (win0),
        .o_col   (win1)
    );

    // Five-point stencil with rounding, centre weighted by four
    assign sum = SUM_BITS'({win0.mid, 2'b00}) + SUM_BITS'(win0.top) + SUM_BITS'(win0.bot)
               + SUM_BITS'(win1.mid) + SUM_BITS'(mid) + SUM_BITS'(4);
    assign smooth   = sum[SUM_BITS-1:3];
    assign interior = (r_b_row != ROW_BITS'(1)) && (r_b_col != COL_BITS'(1));

    // Pick the lowest pending result.
    always_comb begin
        priority if (r_b_pend[0]) begin
            res.temp = interior ? smooth : win0.mid;
            res.row  = r_b_row - ROW_BITS'(1);
            res.col  = r_b_col - COL_BITS'(1);
            res.last = 1'b0;
        end else if (r_b_pend[1]) begin
            res.temp = mid;
            res.row  = r_b_row - ROW_BITS'(1);
            res.col  = r_b_col;
            res.last = 1'b0;
        end else begin
            res.temp = r_b_x;
            res.row  = r_b_row;
            res.col  = r_b_col;
            res.last = (r_b_col == w_last);
        end
    end

    // Result queue towards the master side
    hds_out_queue u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (emit),
        .i_wr_data (res),
        .o_full    (q_full),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rd_data (q_out)
    );

    assign m_axis_tdata = {{PAD_BITS{1'b0}}, q_out.col, q_out.row, q_out.temp};
    assign m_axis_tlast = q_out.last;

endmodule
